// ===== hw/rtl/ssm_pkg.sv =====
// ssm_pkg: shared types, constants and helpers for the substring match splitter
// depends on nothing; used by every rtl file of the block except the two interfaces
package ssm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = WIN_IDX_W + 1;
    localparam int POS_W       = 32;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONLY = 2'd3;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [63:0]      pat_low;
        logic [63:0]      pat_high;
        logic [LEN_W-1:0] len;        // already limited to 1..MAX_PATTERN
        logic             first_only;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic             any_found;
        logic             run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;              // results pushed this cycle, 0..2
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [7:0] pattern_byte(input t_cfg cfg,
                                                input logic [WIN_IDX_W-1:0] k);
        logic [63:0] word;
        word = k[3] ? cfg.pat_high : cfg.pat_low;
        return word[{k[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== hw/rtl/ssm_in_if.sv =====
// ssm_in_if: text byte channel, valid/ready handshake
// depends on nothing
interface ssm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// ===== hw/rtl/ssm_out_if.sv =====
// ssm_out_if: result channel, valid/ready handshake
// depends on nothing
interface ssm_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] position;
    logic        any_found;
    logic        run_last;

    modport source (output valid, output result_kind, output position,
                    output any_found, output run_last, input ready);
    modport sink   (input valid, input result_kind, input position,
                    input any_found, input run_last, output ready);
endinterface

// ===== hw/rtl/ssm_cfg_regs.sv =====
// ssm_cfg_regs: configuration registers with pattern length limiting
// depends on ssm_pkg
module ssm_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ssm_pkg::t_cfg                  o_cfg
);
    logic [63:0]                r_pat_low;
    logic [63:0]                r_pat_high;
    logic [ssm_pkg::LEN_W-1:0]  r_len;
    logic                       r_first_only;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low    <= '0;
            r_pat_high   <= '0;
            r_len        <= ssm_pkg::LEN_W'(1);
            r_first_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssm_pkg::CFG_PAT_LOW:    r_pat_low    <= i_cfg_data;
                ssm_pkg::CFG_PAT_HIGH:   r_pat_high   <= i_cfg_data;
                ssm_pkg::CFG_PAT_LEN:    r_len        <= i_cfg_data[ssm_pkg::LEN_W-1:0];
                ssm_pkg::CFG_FIRST_ONLY: r_first_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.pat_low    = r_pat_low;
        o_cfg.pat_high   = r_pat_high;
        o_cfg.first_only = r_first_only;
        if (r_len == '0) begin
            o_cfg.len = ssm_pkg::LEN_W'(1);
        end else if (r_len > ssm_pkg::LEN_W'(ssm_pkg::MAX_PATTERN)) begin
            o_cfg.len = ssm_pkg::LEN_W'(ssm_pkg::MAX_PATTERN);
        end else begin
            o_cfg.len = r_len;
        end
    end
endmodule

// ===== hw/rtl/ssm_match_stage.sv =====
// ssm_match_stage: input register, window compare and stream state update
// depends on ssm_pkg; feeds ssm_result_fifo
module ssm_match_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssm_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_text_byte,
    input  logic          i_text_last,
    input  logic          i_room,
    output ssm_pkg::t_push o_push
);
    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic [7:0]                   r_win [ssm_pkg::MAX_PATTERN];
    logic [ssm_pkg::POS_W-1:0]    r_pos;
    logic [ssm_pkg::POS_W-1:0]    r_next_start;
    logic                         r_seen;

    logic [7:0]                   win_new [ssm_pkg::MAX_PATTERN];
    logic [ssm_pkg::POS_W-1:0]    count;
    logic [ssm_pkg::POS_W-1:0]    start;
    logic                         bytes_eq;
    logic                         take;
    logic                         seen_new;
    logic                         advance;
    logic [ssm_pkg::WIN_IDX_W-1:0] v_idx;
    ssm_pkg::t_result             res_match;
    ssm_pkg::t_result             res_end;

    assign advance = r_in_valid && i_room;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_text_last;
        end
    end

    // window slot 0 holds the newest byte
    always_comb begin
        win_new[0] = r_in_byte;
        for (int i = 1; i < ssm_pkg::MAX_PATTERN; i++) begin
            win_new[i] = r_win[i-1];
        end
    end

    always_comb begin
        bytes_eq = 1'b1;
        v_idx    = '0;
        for (int i = 0; i < ssm_pkg::MAX_PATTERN; i++) begin
            // slot i lines up with pattern byte len-1-i
            v_idx = ssm_pkg::WIN_IDX_W'(i_cfg.len - ssm_pkg::LEN_W'(1))
                    - ssm_pkg::WIN_IDX_W'(i);
            if ((ssm_pkg::LEN_W'(i) < i_cfg.len)
                    && (win_new[i] != ssm_pkg::pattern_byte(i_cfg, v_idx))) begin
                bytes_eq = 1'b0;
            end
        end
    end

    always_comb begin
        count = (r_pos == ssm_pkg::POS_MAX) ? ssm_pkg::POS_MAX
                                            : r_pos + ssm_pkg::POS_W'(1);
        start = count - ssm_pkg::POS_W'(i_cfg.len);
        // start + len is count itself, so the next allowed start never overflows
        take = bytes_eq && (count >= ssm_pkg::POS_W'(i_cfg.len))
               && (start >= r_next_start) && !(i_cfg.first_only && r_seen);
        seen_new = r_seen || take;

        res_match.kind      = ssm_pkg::KIND_MATCH;
        res_match.position  = start;
        res_match.any_found = 1'b1;
        res_match.run_last  = !r_in_last;

        res_end.kind      = ssm_pkg::KIND_END;
        res_end.position  = count;
        res_end.any_found = seen_new;
        res_end.run_last  = 1'b1;

        o_push.res1 = res_end;
        if (take) begin
            o_push.res0 = res_match;
        end else begin
            o_push.res0 = res_end;
        end
        if (!advance) begin
            o_push.num = 2'd0;
        end else begin
            o_push.num = 2'(take) + 2'(r_in_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ssm_pkg::MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
            r_pos        <= '0;
            r_next_start <= '0;
            r_seen       <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                for (int i = 0; i < ssm_pkg::MAX_PATTERN; i++) begin
                    r_win[i] <= '0;
                end
                r_pos        <= '0;
                r_next_start <= '0;
                r_seen       <= 1'b0;
            end else begin
                for (int i = 0; i < ssm_pkg::MAX_PATTERN; i++) begin
                    r_win[i] <= win_new[i];
                end
                r_pos  <= count;
                r_seen <= seen_new;
                if (take) begin
                    r_next_start <= count;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/ssm_result_fifo.sv =====
// ssm_result_fifo: small result queue taking up to two results a cycle
// depends on ssm_pkg; drains into the result channel
module ssm_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssm_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output ssm_pkg::t_result o_head
);
    ssm_pkg::t_result              r_mem [ssm_pkg::FIFO_DEPTH];
    logic [ssm_pkg::FIFO_PTR_W-1:0] r_wr;
    logic [ssm_pkg::FIFO_PTR_W-1:0] r_rd;
    logic [ssm_pkg::FIFO_CNT_W-1:0] r_cnt;
    logic [ssm_pkg::FIFO_CNT_W-1:0] n_cnt;
    logic                           pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a worst-case item of two results
    assign o_room  = (r_cnt <= ssm_pkg::FIFO_CNT_W'(ssm_pkg::FIFO_DEPTH - 2));
    assign n_cnt   = r_cnt + ssm_pkg::FIFO_CNT_W'(i_push.num)
                     - ssm_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + ssm_pkg::FIFO_PTR_W'(i_push.num);
            r_rd  <= r_rd + ssm_pkg::FIFO_PTR_W'(pop);
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr + ssm_pkg::FIFO_PTR_W'(1)] <= i_push.res1;
        end
    end
endmodule

// ===== hw/rtl/substring_match_splitter_core.sv =====
// path: an accepted item is registered in the match stage input register, and its results are
//   then written into the result queue, which presents them on the result channel
// throughput: one item per cycle while the result queue has room; an item giving a match
//   and an end result takes two result transfers, set by the one-result-per-cycle output
// reset (synchronous, active low) clears the input and result queues, the byte window,
//   position, next allowed start and match flag, and loads the register defaults
module substring_match_splitter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ssm_in_if.sink                         i_text,
    ssm_out_if.source                      o_result
);
    ssm_pkg::t_cfg    cfg;
    ssm_pkg::t_push   push;
    ssm_pkg::t_result head;
    logic             room;

    ssm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssm_match_stage u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_text.valid),
        .o_ready     (i_text.ready),
        .i_text_byte (i_text.text_byte),
        .i_text_last (i_text.text_last),
        .i_room      (room),
        .o_push      (push)
    );

    ssm_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_head  (head)
    );

    assign o_result.result_kind = head.kind;
    assign o_result.position    = head.position;
    assign o_result.any_found   = head.any_found;
    assign o_result.run_last    = head.run_last;
endmodule

// ===== hw/rtl/ssm_checker.sv =====
// ssm_checker: port-level checks on the result channel of the match splitter
// depends on ssm_pkg; bound to substring_match_splitter_core below
module ssm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [31:0] i_out_position,
    input logic        i_out_any_found,
    input logic        i_out_run_last
);
    // a match always counts as found
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == ssm_pkg::KIND_MATCH) |-> i_out_any_found)
        else $error("match item without any_found");

    // the end summary closes its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == ssm_pkg::KIND_END) |-> i_out_run_last)
        else $error("end item not marked last");

    // a match that is not last is followed by the end summary of the same item
    a_match_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_kind == ssm_pkg::KIND_MATCH)
            && !i_out_run_last |=> i_out_valid && (i_out_kind == ssm_pkg::KIND_END))
        else $error("match not followed by end item");

    a_idle_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_position)
            && $stable(i_out_kind))
        else $error("stalled result changed");
endmodule

bind substring_match_splitter_core ssm_checker u_ssm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_kind      (o_result.result_kind),
    .i_out_position  (o_result.position),
    .i_out_any_found (o_result.any_found),
    .i_out_run_last  (o_result.run_last)
);
